>>> hw/rtl/indent_paren_inserter_macros.svh
// Assertion macros used by the indent paren inserter top level.
`ifndef INDENT_PAREN_INSERTER_MACROS_SVH
`define INDENT_PAREN_INSERTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPI_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPI_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ipi_pkg.sv
// Types, codes and helper functions of the indent paren inserter.
package ipi_pkg;

  localparam int STACK_DEPTH_DEF       = 32;
  localparam int LINE_BUFFER_DEPTH_DEF = 16;
  localparam int MAX_RESULTS           = 48;
  localparam int EMIT_CNT_W            = $clog2(MAX_RESULTS + 1);

  // Input token classes.
  localparam logic [2:0] KIND_INDENT = 3'd0;
  localparam logic [2:0] KIND_OPEN   = 3'd1;
  localparam logic [2:0] KIND_CLOSE  = 3'd2;
  localparam logic [2:0] KIND_QUOTE  = 3'd3;
  localparam logic [2:0] KIND_WORD   = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;

  // Result codes.
  localparam logic [2:0] OUT_OPEN      = 3'd0;
  localparam logic [2:0] OUT_CLOSE     = 3'd1;
  localparam logic [2:0] OUT_QUOTE     = 3'd2;
  localparam logic [2:0] OUT_WORD      = 3'd3;
  localparam logic [2:0] OUT_INS_OPEN  = 3'd4;
  localparam logic [2:0] OUT_INS_CLOSE = 3'd5;

  localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  indent_level;
    logic [31:0] token_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] out_tag;
    logic        unbalanced_error;
    logic        overflow_error;
    logic        last_of_run;
  } out_item_t;

  // One held token of the current line.
  typedef struct packed {
    logic [2:0]  ok;
    logic [31:0] tag;
  } buf_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TOP_RD,
    ST_TOP_CHK,
    ST_INSERT,
    ST_FL_RD,
    ST_FL_EMIT,
    ST_PASS,
    ST_CL_RD,
    ST_CL_EMIT,
    ST_FINISH
  } ipi_state_t;

  typedef struct packed {
    logic latch_tok;
    logic dec_commit;
    logic stk_rd_top;
    logic stk_rd_next;
    logic set_close_any;
    logic buf_rd;
    logic emit_buf;
    logic emit_ins;
    logic emit_tok;
    logic emit_close;
    logic finish_bnd;
  } ipi_cmd_t;

  typedef struct packed {
    logic kind_ign;
    logic kind_bnd;
    logic tok_store;
    logic tok_insert;
    logic buf_nonempty;
    logic buf_more;
    logic close_now;
    logic close_any;
    logic next_close;
    logic can_emit;
  } ipi_sts_t;

  // Maps a real token class to its result code.
  function automatic logic [2:0] tok_out_kind(input logic [2:0] kind);
    logic [2:0] res;
    unique case (kind)
      KIND_OPEN:  res = OUT_OPEN;
      KIND_CLOSE: res = OUT_CLOSE;
      KIND_QUOTE: res = OUT_QUOTE;
      default:    res = OUT_WORD;
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/ipi_dp.sv
// Datapath of the indent paren inserter: token register, line state, memories, output register.
module ipi_dp #(
  parameter int STACK_DEPTH       = ipi_pkg::STACK_DEPTH_DEF,
  parameter int LINE_BUFFER_DEPTH = ipi_pkg::LINE_BUFFER_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ipi_pkg::in_item_t   in_data,
  input  ipi_pkg::ipi_cmd_t   cmd,
  output ipi_pkg::ipi_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output ipi_pkg::out_item_t  out_data
);
  import ipi_pkg::*;

  localparam int SC_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int BC_W = $clog2(LINE_BUFFER_DEPTH + 1);
  localparam int BA_W = $clog2(LINE_BUFFER_DEPTH);

  logic [7:0]      stack_mem [STACK_DEPTH];
  buf_entry_t      buf_mem   [LINE_BUFFER_DEPTH];

  in_item_t               tok_r;
  logic signed [15:0]     depth_r, depth_nxt;
  logic [SC_W-1:0]        sc_r, sc_m1, sc_m2;
  logic [7:0]             line_indent_r;
  logic [BC_W-1:0]        bc_r;
  logic                   open_r, decided_r, first_r;
  logic [1:0]             words_r;
  logic                   ovf_r, close_any_r;
  logic [BA_W-1:0]        idx_r;
  logic [EMIT_CNT_W-1:0]  cnt_r;
  logic [7:0]             stk_rdata_r;
  buf_entry_t             buf_rdata_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  // Token decode for the held line.
  logic       is_tok, is_bnd, is_end;
  logic       decided_e, first_e;
  logic [1:0] words_e;
  logic       first_c, dec_c, ovf_c, ins_c, store_c;
  logic [1:0] words_c;
  logic       dec_first, ins_cond, dec_any;
  logic       sc_room, bc_room;

  always_comb begin
    is_end  = (tok_r.kind == KIND_END);
    is_bnd  = (tok_r.kind == KIND_INDENT) || is_end;
    is_tok  = (tok_r.kind == KIND_OPEN) || (tok_r.kind == KIND_CLOSE) ||
              (tok_r.kind == KIND_QUOTE) || (tok_r.kind == KIND_WORD);
    sc_room = (sc_r < SC_W'(STACK_DEPTH));
    bc_room = (bc_r < BC_W'(LINE_BUFFER_DEPTH));
    // A token outside any line opens one at the current indent.
    decided_e = open_r ? decided_r : (depth_r != 16'sd0);
    first_e   = open_r ? first_r : 1'b0;
    words_e   = open_r ? words_r : 2'd0;

    dec_first = (tok_r.kind == KIND_OPEN) && !first_e;
    words_c   = ((tok_r.kind == KIND_WORD) && (words_e < 2'd2)) ? words_e + 2'd1 : words_e;
    ins_cond  = !dec_first && (words_c >= 2'd2);
    dec_any   = dec_first || ins_cond;

    if (decided_e) begin
      first_c = first_e;
      words_c = words_e;
      dec_c   = 1'b1;
      ovf_c   = 1'b0;
      ins_c   = 1'b0;
      store_c = 1'b0;
    end else begin
      first_c = first_e || (tok_r.kind != KIND_QUOTE);
      dec_c   = dec_any || !bc_room;
      ins_c   = ins_cond && sc_room;
      ovf_c   = (ins_cond && !sc_room) || (!dec_any && !bc_room);
      store_c = !dec_any && bc_room;
    end
  end

  // Explicit paren count, updated by every passed token.
  logic [2:0] pass_ok;
  logic       pass_en;

  always_comb begin
    pass_ok   = cmd.emit_buf ? buf_rdata_r.ok : tok_out_kind(tok_r.kind);
    pass_en   = cmd.emit_buf || cmd.emit_tok;
    depth_nxt = depth_r;
    if ((pass_ok == OUT_OPEN) && (depth_r != DEPTH_MAX)) begin
      depth_nxt = depth_r + 16'sd1;
    end else if ((pass_ok == OUT_CLOSE) && (depth_r != DEPTH_MIN)) begin
      depth_nxt = depth_r - 16'sd1;
    end
  end

  logic stk_ge, buf_more, capped, emit, load, last_nat;
  out_item_t res;

  always_comb begin
    sc_m1    = sc_r - SC_W'(1);
    sc_m2    = sc_r - SC_W'(2);
    stk_ge   = is_end || (stk_rdata_r >= tok_r.indent_level);
    buf_more = (BC_W'(idx_r) + BC_W'(1)) < bc_r;
    capped   = (cnt_r == EMIT_CNT_W'(MAX_RESULTS));
    emit     = cmd.emit_buf || cmd.emit_ins || cmd.emit_tok || cmd.emit_close;
    load     = emit && !capped;

    res = '0;
    res.overflow_error = ovf_r;
    last_nat = 1'b0;
    priority if (cmd.emit_ins) begin
      res.out_kind = OUT_INS_OPEN;
    end else if (cmd.emit_close) begin
      res.out_kind = OUT_INS_CLOSE;
      last_nat     = !((sc_r >= SC_W'(2)) && stk_ge);
    end else if (cmd.emit_buf) begin
      res.out_kind         = buf_rdata_r.ok;
      res.out_tag          = buf_rdata_r.tag;
      res.unbalanced_error = depth_nxt[15];
      last_nat             = !buf_more && is_bnd && !close_any_r;
    end else begin
      res.out_kind         = pass_ok;
      res.out_tag          = tok_r.token_tag;
      res.unbalanced_error = depth_nxt[15];
      last_nat             = 1'b1;
    end
    // The final result that fits in a run carries the end mark.
    res.last_of_run = last_nat || (cnt_r == EMIT_CNT_W'(MAX_RESULTS - 1));
  end

  always_comb begin
    sts.kind_ign     = !is_tok && !is_bnd;
    sts.kind_bnd     = is_bnd;
    sts.tok_store    = store_c;
    sts.tok_insert   = ins_c;
    sts.buf_nonempty = (bc_r != '0);
    sts.buf_more     = buf_more;
    sts.close_now    = (sc_r != '0) && stk_ge;
    sts.close_any    = close_any_r;
    sts.next_close   = (sc_r >= SC_W'(2)) && stk_ge;
    sts.can_emit     = !out_valid_r || out_ready || capped;
  end

  // Memories, read registers, token register and output register.
  always_ff @(posedge clk) begin
    if (cmd.emit_ins) begin
      stack_mem[sc_r[SA_W-1:0]] <= line_indent_r;
    end
    if (cmd.stk_rd_top && (sc_r != '0)) begin
      stk_rdata_r <= stack_mem[sc_m1[SA_W-1:0]];
    end else if (cmd.stk_rd_next && (sc_r >= SC_W'(2))) begin
      stk_rdata_r <= stack_mem[sc_m2[SA_W-1:0]];
    end
    if (cmd.dec_commit && store_c) begin
      buf_mem[bc_r[BA_W-1:0]] <= '{ok: tok_out_kind(tok_r.kind), tag: tok_r.token_tag};
    end
    if (cmd.buf_rd) begin
      buf_rdata_r <= buf_mem[idx_r];
    end
    if (cmd.latch_tok) begin
      tok_r <= in_data;
    end
    if (load) begin
      out_r <= res;
    end
  end

  // Line and stack state, flush index, run count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r       <= '0;
      sc_r          <= '0;
      line_indent_r <= '0;
      bc_r          <= '0;
      open_r        <= 1'b0;
      decided_r     <= 1'b0;
      first_r       <= 1'b0;
      words_r       <= '0;
      ovf_r         <= 1'b0;
      close_any_r   <= 1'b0;
      idx_r         <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.latch_tok) begin
        ovf_r <= 1'b0;
        cnt_r <= '0;
      end
      if (cmd.dec_commit) begin
        open_r    <= 1'b1;
        decided_r <= dec_c;
        first_r   <= first_c;
        words_r   <= words_c;
        ovf_r     <= ovf_c;
        if (store_c) begin
          bc_r <= bc_r + BC_W'(1);
        end
      end
      if (cmd.set_close_any) begin
        close_any_r <= (sc_r != '0) && stk_ge;
      end
      if (pass_en) begin
        depth_r <= depth_nxt;
      end
      if (cmd.emit_buf) begin
        if (buf_more) begin
          idx_r <= idx_r + BA_W'(1);
        end else begin
          idx_r <= '0;
          bc_r  <= '0;
        end
      end
      if (cmd.emit_ins) begin
        sc_r <= sc_r + SC_W'(1);
      end else if (cmd.emit_close) begin
        sc_r <= sc_m1;
      end
      if (cmd.finish_bnd) begin
        bc_r    <= '0;
        first_r <= 1'b0;
        words_r <= '0;
        if (is_end) begin
          depth_r       <= '0;
          sc_r          <= '0;
          line_indent_r <= '0;
          open_r        <= 1'b0;
          decided_r     <= 1'b0;
        end else begin
          line_indent_r <= tok_r.indent_level;
          open_r        <= 1'b1;
          decided_r     <= (depth_r != 16'sd0);
        end
      end
      if (load) begin
        cnt_r <= cnt_r + EMIT_CNT_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/ipi_ctrl.sv
// Controller state machine of the indent paren inserter.
module ipi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ipi_pkg::ipi_sts_t  sts,
  output ipi_pkg::ipi_cmd_t  cmd
);
  import ipi_pkg::*;

  ipi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (sts.kind_ign)   state_nxt = ST_IDLE;
        else if (sts.kind_bnd)       state_nxt = ST_TOP_RD;
        else if (sts.tok_store)      state_nxt = ST_IDLE;
        else if (sts.tok_insert)     state_nxt = ST_INSERT;
        else if (sts.buf_nonempty)   state_nxt = ST_FL_RD;
        else                         state_nxt = ST_PASS;
      end
      ST_TOP_RD: state_nxt = ST_TOP_CHK;
      ST_TOP_CHK: begin
        priority if (sts.buf_nonempty) state_nxt = ST_FL_RD;
        else if (sts.close_now)        state_nxt = ST_CL_RD;
        else                           state_nxt = ST_FINISH;
      end
      ST_INSERT: begin
        if (sts.can_emit) state_nxt = sts.buf_nonempty ? ST_FL_RD : ST_PASS;
      end
      ST_FL_RD: state_nxt = ST_FL_EMIT;
      ST_FL_EMIT: begin
        if (sts.can_emit) begin
          priority if (sts.buf_more) state_nxt = ST_FL_RD;
          else if (!sts.kind_bnd)    state_nxt = ST_PASS;
          else if (sts.close_any)    state_nxt = ST_CL_RD;
          else                       state_nxt = ST_FINISH;
        end
      end
      ST_PASS: begin
        if (sts.can_emit) state_nxt = ST_IDLE;
      end
      ST_CL_RD: state_nxt = ST_CL_EMIT;
      ST_CL_EMIT: begin
        if (sts.can_emit) state_nxt = sts.next_close ? ST_CL_RD : ST_FINISH;
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_tok = in_valid;
      end
      ST_DECODE:  cmd.dec_commit    = !sts.kind_ign && !sts.kind_bnd;
      ST_TOP_RD:  cmd.stk_rd_top    = 1'b1;
      ST_TOP_CHK: cmd.set_close_any = 1'b1;
      ST_INSERT:  cmd.emit_ins      = sts.can_emit;
      ST_FL_RD:   cmd.buf_rd        = 1'b1;
      ST_FL_EMIT: cmd.emit_buf      = sts.can_emit;
      ST_PASS:    cmd.emit_tok      = sts.can_emit;
      ST_CL_RD:   cmd.stk_rd_next   = 1'b1;
      ST_CL_EMIT: cmd.emit_close    = sts.can_emit;
      ST_FINISH:  cmd.finish_bnd    = 1'b1;
      default:    cmd               = '0;
    endcase
  end

endmodule

>>> hw/rtl/indent_paren_inserter.sv
// Top level of the indent paren inserter: controller, datapath and checks.
//
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    ipi_pkg::in_item_t  (kind, indent_level, token_tag)
// out_     output     out_valid / out_ready  ipi_pkg::out_item_t (kind, tag, error flags, last)
//
// A token held in the line buffer runs ST_DECODE back to ST_IDLE; a token passed on adds ST_PASS.
// Each flushed token and each closed inserted paren takes a read state and an emit state, set by
// the registered read ports of the line buffer and the indent stack; an indent or end token adds
// ST_TOP_RD, ST_TOP_CHK and ST_FINISH. Reset is synchronous; both memories are read only below
// their fill counts, so no clearing. out_ready low holds the controller on the pending result;
// in_ready rises once the last result of a token has entered the output register.
`include "indent_paren_inserter_macros.svh"

module indent_paren_inserter #(
  parameter int STACK_DEPTH       = ipi_pkg::STACK_DEPTH_DEF,
  parameter int LINE_BUFFER_DEPTH = ipi_pkg::LINE_BUFFER_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipi_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipi_pkg::out_item_t  out_data
);
  import ipi_pkg::*;

  ipi_cmd_t cmd;
  ipi_sts_t sts;
  logic     emit_any;

  ipi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipi_dp #(
    .STACK_DEPTH       (STACK_DEPTH),
    .LINE_BUFFER_DEPTH (LINE_BUFFER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign emit_any = cmd.emit_buf || cmd.emit_ins || cmd.emit_tok || cmd.emit_close;

  // A result is only produced when the output register can take it.
  `IPI_ASSERT_IMPL(a_emit_has_room, clk, rst_n, emit_any, sts.can_emit, "result emitted without room")
  // One transaction at a time: the token just taken blocks the next.
  `IPI_ASSERT_NEXT(a_one_token, clk, rst_n, in_valid && in_ready, !in_ready, "second token taken")
  // Nothing is emitted while the block waits for a token.
  `IPI_ASSERT_IMPL(a_idle_quiet, clk, rst_n, in_ready, !emit_any, "result emitted while idle")

endmodule
